// File: hdl/isp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isp_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 65536;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned ADDR_IN_W = 16;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned POS_W     = 48;
  localparam int unsigned VOL_W     = 16;
  localparam int unsigned LEN_CFG_W = 17;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned IN_DATA_W = 80;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RATE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd4;

  localparam logic REG_VOLUME = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  localparam logic [VOL_W-1:0]     VOLUME_RESET = 16'h8000;
  localparam logic [LEN_CFG_W-1:0] LENGTH_RESET = '0;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_START,
    OP_STOP,
    OP_RATE,
    OP_TICK
  } isp_op_t;

  typedef struct packed {
    isp_op_t                     op;
    logic [ADDR_IN_W-1:0]        address;
    logic signed [SAMPLE_W-1:0]  left;
    logic signed [SAMPLE_W-1:0]  right;
    logic [RATE_W-1:0]           rate;
  } isp_item_t;

endpackage

`default_nettype wire

// File: hdl/interpolating_sample_player_unit.sv
// Stereo sample player with linear interpolation.
// Input stream (s_*): s_tuser carries the item kind (write, start, stop,
// set rate, tick); s_tdata carries address, left and right sample and rate.
// Output stream (m_*): one frame per tick item; m_tdata holds left in the low
// half and right in the high half, m_tuser is the active flag. Other items
// give no frame.
// Config port: cfg_we/cfg_index/cfg_data write volume (index 0) and sample
// length (index 1); write them only while no item is in flight.
// A two-entry queue sits between the front end and the playback engine.
// Write, start, stop and rate items are carried out in the idle step. A tick
// that yields silence goes straight to the hand-off step; one that
// interpolates passes through memory read, interpolation multiply, volume
// multiply, and round and clamp before the step that hands the frame to the
// output register; the sequencer handles one item at a time.
// A stalled receiver holds the frame in the output register; the engine then
// waits in its hand-off step and the queue fills, after which s_tready drops.
// Reset (rst, synchronous): queue empty, playback stopped, position 0, rate
// 1.0, unity volume, length 0. Sample memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module interpolating_sample_player_unit #(
  parameter int unsigned STORE_DEPTH = isp_pkg::STORE_DEPTH_DEF,
  parameter int unsigned FRAC_BITS   = isp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  // address[15:0], left_in[31:16], right_in[47:32], rate_in[79:48]
  input  wire logic [isp_pkg::IN_DATA_W-1:0]    s_tdata,
  // kind[2:0]
  input  wire logic [isp_pkg::KIND_W-1:0]       s_tuser,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  // left_out[15:0], right_out[31:16]
  output      logic [isp_pkg::OUT_DATA_W-1:0]   m_tdata,
  // active[0]
  output      logic                             m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [isp_pkg::LEN_CFG_W-1:0]    cfg_data
);
  import isp_pkg::*;

  logic                        q_valid;
  isp_item_t                   q_item;
  logic                        q_pop;
  logic signed [SAMPLE_W-1:0]  left_out;
  logic signed [SAMPLE_W-1:0]  right_out;

  isp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  isp_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .left_out  (left_out),
    .right_out (right_out),
    .active    (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready)
  );

  assign m_tdata = {right_out, left_out};

endmodule

`default_nettype wire

// File: hdl/isp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module isp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output      logic [WIDTH-1:0] rdata_a,
  output      logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: hdl/isp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module isp_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  input  wire logic [isp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [isp_pkg::KIND_W-1:0]     s_tuser,
  output      logic                           q_valid,
  output      isp_pkg::isp_item_t             q_item,
  input  wire logic                           q_pop
);
  import isp_pkg::*;

  isp_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  isp_item_t  decoded;
  logic       keep;
  logic       push;

  always_comb begin
    decoded.address = s_tdata[15:0];
    decoded.left    = s_tdata[31:16];
    decoded.right   = s_tdata[47:32];
    decoded.rate    = s_tdata[79:48];
    decoded.op      = OP_TICK;
    keep            = 1'b1;
    case (s_tuser)
      KIND_WRITE: decoded.op = OP_WRITE;
      KIND_START: decoded.op = OP_START;
      KIND_STOP:  decoded.op = OP_STOP;
      KIND_RATE:  decoded.op = OP_RATE;
      KIND_TICK:  decoded.op = OP_TICK;
      // unknown kinds: take the transfer, drop the item
      default:    keep = 1'b0;
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready && keep;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= decoded;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/isp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module isp_back #(
  parameter int unsigned STORE_DEPTH = isp_pkg::STORE_DEPTH_DEF,
  parameter int unsigned FRAC_BITS   = isp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_valid,
  input  wire isp_pkg::isp_item_t                  q_item,
  output      logic                                q_pop,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [isp_pkg::LEN_CFG_W-1:0]       cfg_data,
  output      logic signed [isp_pkg::SAMPLE_W-1:0] left_out,
  output      logic signed [isp_pkg::SAMPLE_W-1:0] right_out,
  output      logic                                active,
  output      logic                                m_tvalid,
  input  wire logic                                m_tready
);
  import isp_pkg::*;

  localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LEN_W  =
    ($clog2(STORE_DEPTH + 1) > LEN_CFG_W) ? $clog2(STORE_DEPTH + 1) : LEN_CFG_W;
  localparam int unsigned VW     = SAMPLE_W + 2 + FRAC_BITS;
  localparam int unsigned PW     = VW + VOL_W + 1;
  localparam int unsigned SH     = FRAC_BITS + VOL_W - 1;
  localparam int unsigned QW     = PW - SH;
  localparam int unsigned SUM_W  = POS_W + 1;
  localparam int unsigned MEM_W  = 2 * SAMPLE_W;

  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = QW'(-32768);
  localparam logic [RATE_W-1:0]    RATE_ONE = RATE_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTERP,
    ST_SCALE,
    ST_ROUND,
    ST_DONE
  } state_t;

  state_t                      state;
  logic [POS_W-1:0]            read_position;
  logic [RATE_W-1:0]           step_rate;
  logic                        running;
  logic [VOL_W-1:0]            volume;
  logic [LEN_CFG_W-1:0]        sample_length;
  logic [FRAC_BITS-1:0]        frac;
  logic signed [VW-1:0]        v_left;
  logic signed [VW-1:0]        v_right;
  logic signed [PW-1:0]        p_left;
  logic signed [PW-1:0]        p_right;
  logic signed [SAMPLE_W-1:0]  res_left;
  logic signed [SAMPLE_W-1:0]  res_right;
  logic                        res_active;

  logic [LEN_W-1:0]            len_ext;
  logic [LEN_W-1:0]            len_c;
  logic [POS_W-1:0]            end_pos;
  logic [ADDR_W-1:0]           idx;
  logic [ADDR_W-1:0]           idx_next;
  logic [SUM_W-1:0]            pos_sum;
  logic [POS_W-1:0]            pos_sat;
  logic                        addr_ok;
  logic                        ram_we;
  logic [MEM_W-1:0]            rdata_a;
  logic [MEM_W-1:0]            rdata_b;
  logic                        out_free;

  function automatic logic signed [VW-1:0] interp(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [FRAC_BITS-1:0]       f
  );
    logic signed [SAMPLE_W:0] d;
    logic signed [VW-1:0]     d_w;
    logic signed [VW-1:0]     f_w;
    begin
      d   = $signed({b[SAMPLE_W-1], b}) - $signed({a[SAMPLE_W-1], a});
      d_w = VW'(d);
      f_w = VW'($signed({1'b0, f}));
      return (VW'(a) <<< FRAC_BITS) + d_w * f_w;
    end
  endfunction

  // truncate toward zero, then clamp to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] scale_out(
    input logic signed [PW-1:0] p
  );
    logic signed [PW-1:0] adj;
    logic signed [QW-1:0] q;
    begin
      adj = p + $signed({{(PW - SH){1'b0}}, {SH{p[PW-1]}}});
      q   = QW'(adj >>> SH);
      if (q > Q_MAX) begin
        return 16'sh7FFF;
      end else if (q < Q_MIN) begin
        return 16'sh8000;
      end else begin
        return q[SAMPLE_W-1:0];
      end
    end
  endfunction

  always_comb begin
    len_ext  = LEN_W'(sample_length);
    len_c    = (len_ext > LEN_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : len_ext;
    end_pos  = POS_W'(len_c - LEN_W'(1)) << FRAC_BITS;
    idx      = read_position[FRAC_BITS +: ADDR_W];
    idx_next = idx + ADDR_W'(1);
    pos_sum  = {1'b0, read_position} + SUM_W'(step_rate);
    pos_sat  = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
    addr_ok  = LEN_W'(q_item.address) < LEN_W'(STORE_DEPTH);
  end

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign ram_we   = q_pop && (q_item.op == OP_WRITE) && addr_ok;
  assign out_free = !m_tvalid || m_tready;

  isp_ram #(
    .WIDTH (MEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ADDR_W'(q_item.address)),
    .wdata   ({q_item.right, q_item.left}),
    .raddr_a (idx),
    .raddr_b (idx_next),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      read_position <= '0;
      step_rate     <= RATE_ONE;
      running       <= 1'b0;
      volume        <= VOLUME_RESET;
      sample_length <= LENGTH_RESET;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VOLUME: volume        <= cfg_data[VOL_W-1:0];
          REG_LENGTH: sample_length <= cfg_data;
          default:    volume        <= volume;
        endcase
      end
      // a frame handed over in the done step sets valid again below
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.op)
              OP_START: begin
                read_position <= '0;
                step_rate     <= RATE_ONE;
                running       <= 1'b1;
              end
              OP_STOP: begin
                read_position <= '0;
                running       <= 1'b0;
              end
              OP_RATE: begin
                step_rate <= q_item.rate;
              end
              OP_TICK: begin
                res_left  <= '0;
                res_right <= '0;
                if (!running || len_c == '0) begin
                  res_active <= running;
                  state      <= ST_DONE;
                end else if (read_position >= end_pos) begin
                  running    <= 1'b0;
                  res_active <= 1'b0;
                  state      <= ST_DONE;
                end else begin
                  // neighbors are being read; advance now
                  frac          <= read_position[FRAC_BITS-1:0];
                  read_position <= pos_sat;
                  res_active    <= 1'b1;
                  state         <= ST_INTERP;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_INTERP: begin
          v_left  <= interp(rdata_a[SAMPLE_W-1:0], rdata_b[SAMPLE_W-1:0], frac);
          v_right <= interp(rdata_a[MEM_W-1:SAMPLE_W], rdata_b[MEM_W-1:SAMPLE_W], frac);
          state   <= ST_SCALE;
        end
        ST_SCALE: begin
          p_left  <= PW'(v_left) * PW'($signed({1'b0, volume}));
          p_right <= PW'(v_right) * PW'($signed({1'b0, volume}));
          state   <= ST_ROUND;
        end
        ST_ROUND: begin
          res_left  <= scale_out(p_left);
          res_right <= scale_out(p_right);
          state     <= ST_DONE;
        end
        ST_DONE: begin
          // hold the frame until the output register frees up
          if (out_free) begin
            left_out  <= res_left;
            right_out <= res_right;
            active    <= res_active;
            m_tvalid  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> (state == ST_DONE))
    else $error("frame loaded over a pending output");

  a_pos_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> $stable(read_position))
    else $error("position moved outside an item");

  a_active_tracks_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (res_active == running))
    else $error("active flag disagrees with playback state");

  a_pop_idle_only: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_IDLE || state == ST_INTERP || state == ST_DONE))
    else $error("unexpected state after pop");

endmodule

`default_nettype wire
